/* design/srem_pkg.sv */
package srem_pkg;

    localparam int unsigned DATA_W     = 64;
    localparam int unsigned DIV_STAGES = DATA_W;
    localparam int unsigned MODE_W     = 2;
    localparam int unsigned S_TDATA_W  = 2 * DATA_W;

    localparam logic [MODE_W-1:0] MODE_TRUNC  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FLOOR  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EUCLID = 2'd2;

    typedef struct packed {
        logic [DATA_W-1:0] a_sh;
        logic [DATA_W-1:0] p;
        logic [DATA_W-1:0] mag_b;
        logic              a_neg;
        logic              b_neg;
        logic              zero;
        logic [MODE_W-1:0] mode;
    } t_div;

endpackage

/* design/signed_remainder_three_conventions.sv */
// Signed 64-bit remainder, truncated / floored / euclidean chosen by the mode register
// (mode 3 acts as euclidean). Takes one transaction per cycle while the skid register is
// empty; the 64-stage restoring subtract chain computes one quotient bit per stage. A zero
// divisor returns 0 with tuser set.
// An output register plus a skid register separate the two sides, so o_s_axis_tready
// is registered. Write the mode only while no transactions are in flight.
module signed_remainder_three_conventions (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [srem_pkg::MODE_W-1:0]       i_cfg_wr_data,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [srem_pkg::S_TDATA_W-1:0]    i_s_axis_tdata,  // dividend, divisor
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [srem_pkg::DATA_W-1:0]       o_m_axis_tdata,  // remainder
    output logic                              o_m_axis_tuser   // divide_by_zero
);

    localparam int unsigned W = srem_pkg::DATA_W;
    localparam int unsigned N = srem_pkg::DIV_STAGES;

    logic [srem_pkg::MODE_W-1:0] r_mode;
    logic                        w_en;
    logic                        w_acc;

    logic                r_v  [0:N];
    srem_pkg::t_div      r_st [0:N];

    // one restoring step per stage
    logic [W-1:0]        w_trial [0:N-1];
    logic [W:0]          w_sub   [0:N-1];
    srem_pkg::t_div      w_nxt   [0:N-1];

    // diff stage
    logic                        r_dv;
    logic [W-1:0]                r_d_rem;
    logic [W-1:0]                r_d_diff;
    logic                        r_d_aneg;
    logic                        r_d_bneg;
    logic                        r_d_zero;
    logic [srem_pkg::MODE_W-1:0] r_d_mode;

    // post stage
    logic                        r_pv;
    logic [W-1:0]                r_p_res;
    logic                        r_p_dbz;
    logic [W-1:0]                n_res;

    // output and skid
    logic                        r_out_v;
    logic [W-1:0]                r_out_res;
    logic                        r_out_dbz;
    logic                        r_skid_v;
    logic [W-1:0]                r_skid_res;
    logic                        r_skid_dbz;
    logic                        w_out_free;

    logic [W-1:0]                w_a;
    logic [W-1:0]                w_b;
    srem_pkg::t_div              n_st0;

    assign w_en            = !r_skid_v;
    assign o_s_axis_tready = w_en;
    assign w_acc           = i_s_axis_tvalid && w_en;
    assign w_a             = i_s_axis_tdata[W-1:0];
    assign w_b             = i_s_axis_tdata[2*W-1:W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= srem_pkg::MODE_TRUNC;
        end else if (i_cfg_wr_en) begin
            r_mode <= i_cfg_wr_data;
        end
    end

    always_comb begin
        n_st0.a_sh  = w_a[W-1] ? (W'(0) - w_a) : w_a;
        n_st0.p     = '0;
        n_st0.mag_b = w_b[W-1] ? (W'(0) - w_b) : w_b;
        n_st0.a_neg = w_a[W-1];
        n_st0.b_neg = w_b[W-1];
        n_st0.zero  = (w_b == '0);
        n_st0.mode  = r_mode;
    end

    always_comb begin
        for (int unsigned k = 0; k < N; k++) begin
            w_trial[k]     = {r_st[k].p[W-2:0], r_st[k].a_sh[W-1]};
            w_sub[k]       = {1'b0, w_trial[k]} - {1'b0, r_st[k].mag_b};
            w_nxt[k]       = r_st[k];
            w_nxt[k].a_sh  = {r_st[k].a_sh[W-2:0], 1'b0};
            w_nxt[k].p     = w_sub[k][W] ? w_trial[k] : w_sub[k][W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int unsigned k = 0; k <= N; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_v[0] <= w_acc;
            for (int unsigned k = 0; k < N; k++) begin
                r_v[k+1] <= r_v[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_st[0] <= n_st0;
        end
        if (w_en) begin
            for (int unsigned k = 0; k < N; k++) begin
                r_st[k+1] <= w_nxt[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= 1'b0;
        end else if (w_en) begin
            r_dv <= r_v[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_rem  <= r_st[N].p;
            r_d_diff <= r_st[N].mag_b - r_st[N].p;
            r_d_aneg <= r_st[N].a_neg;
            r_d_bneg <= r_st[N].b_neg;
            r_d_zero <= r_st[N].zero;
            r_d_mode <= r_st[N].mode;
        end
    end

    // sign fix-up per convention
    logic         w_nz;
    logic         w_adj;
    logic         w_neg;
    logic [W-1:0] w_mag;

    always_comb begin
        w_nz = (r_d_rem != '0);
        case (r_d_mode)
            srem_pkg::MODE_TRUNC: begin
                w_adj = 1'b0;
                w_neg = r_d_aneg;
            end
            srem_pkg::MODE_FLOOR: begin
                w_adj = w_nz && (r_d_aneg != r_d_bneg);
                w_neg = w_adj ? r_d_bneg : r_d_aneg;
            end
            default: begin
                w_adj = w_nz && r_d_aneg;
                w_neg = w_adj ? 1'b0 : r_d_aneg;
            end
        endcase
        w_mag = w_adj ? r_d_diff : r_d_rem;
        if (r_d_zero) begin
            n_res = '0;
        end else begin
            n_res = w_neg ? (W'(0) - w_mag) : w_mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (w_en) begin
            r_pv <= r_dv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p_res <= n_res;
            r_p_dbz <= r_d_zero;
        end
    end

    assign w_out_free = !r_out_v || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (w_out_free) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end
        end else if (r_pv) begin
            if (w_out_free) begin
                r_out_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (i_m_axis_tready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (w_out_free) begin
                r_out_res <= r_skid_res;
                r_out_dbz <= r_skid_dbz;
            end
        end else if (r_pv) begin
            if (w_out_free) begin
                r_out_res <= r_p_res;
                r_out_dbz <= r_p_dbz;
            end else begin
                r_skid_res <= r_p_res;
                r_skid_dbz <= r_p_dbz;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = r_out_res;
    assign o_m_axis_tuser  = r_out_dbz;

endmodule

/* design/srem_checker.sv */
module srem_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_s_axis_tready,
    input logic                           o_m_axis_tvalid,
    input logic                           i_m_axis_tready,
    input logic [srem_pkg::DATA_W-1:0]    o_m_axis_tdata,
    input logic                           o_m_axis_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("output changed while stalled");

    a_dbz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata == '0)
        else $error("divide by zero with nonzero remainder");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("not idle after reset");

    a_bp_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> $past(o_m_axis_tvalid && !i_m_axis_tready))
        else $error("input stalled without output back-pressure");

endmodule

bind signed_remainder_three_conventions srem_checker u_srem_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned DATA_W    = srem_pkg::DATA_W;
    localparam int unsigned MODE_W    = srem_pkg::MODE_W;
    localparam int unsigned S_TDATA_W = srem_pkg::S_TDATA_W;

    localparam int IDLE_PCT     = 14;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 300;
    localparam int CALM_FROM    = 700;
    localparam int CALM_TO      = 1000;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 100;
    localparam int RAND_PER_SET = 140;

    localparam logic [DATA_W-1:0] INT_MIN  = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] INT_MAX  = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] MINUS_1  = {DATA_W{1'b1}};

    typedef struct packed {
        logic [DATA_W-1:0] rem;
        logic              dz;
    } t_rem_result;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_wr_en;
    logic [MODE_W-1:0]      i_cfg_wr_data;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [S_TDATA_W-1:0]   i_s_axis_tdata;   // dividend, divisor
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [DATA_W-1:0]      o_m_axis_tdata;   // remainder
    logic                   o_m_axis_tuser;   // divide_by_zero

    logic [S_TDATA_W-1:0]   operand_fifo[$];
    t_rem_result            remainder_due[$];
    logic [MODE_W-1:0]      mode_copy;
    int                     in_cnt;
    int                     err_cnt;
    int                     hold_left;
    bit                     hold_done;
    int                     stall_cnt;
    bit                     calm;

    signed_remainder_three_conventions dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [DATA_W-1:0] mag_of(logic [DATA_W-1:0] v);
        return v[DATA_W-1] ? (DATA_W'(0) - v) : v;
    endfunction

    function automatic t_rem_result predict_remainder(logic [MODE_W-1:0] mode,
                                                      logic [DATA_W-1:0] a,
                                                      logic [DATA_W-1:0] b);
        t_rem_result       res;
        logic [DATA_W-1:0] r;
        logic [DATA_W-1:0] t;
        res.dz  = 1'b0;
        res.rem = '0;
        if (b == '0) begin
            res.dz = 1'b1;
            return res;
        end
        r = mag_of(a) % mag_of(b);
        t = a[DATA_W-1] ? (DATA_W'(0) - r) : r;
        if (mode == srem_pkg::MODE_FLOOR) begin
            if (r != '0 && a[DATA_W-1] != b[DATA_W-1]) t = t + b;
        end else if (mode >= srem_pkg::MODE_EUCLID) begin
            if (r != '0 && a[DATA_W-1]) t = t + mag_of(b);
        end
        res.rem = t;
        return res;
    endfunction

    function automatic logic [DATA_W-1:0] rand_word();
        logic [DATA_W-1:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1:    ;
            2:       w = DATA_W'($urandom_range(0, 200)) - DATA_W'(100);
            3:       w = INT_MIN;
            4:       w = INT_MAX;
            5:       w = '0;
            6:       w = MINUS_1;
            default: begin
                w = w >> $urandom_range(0, DATA_W - 1);
                if ($urandom_range(0, 1)) w = DATA_W'(0) - w;
            end
        endcase
        return w;
    endfunction

    function automatic logic [S_TDATA_W-1:0] rand_pair();
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        a = rand_word();
        b = rand_word();
        // divisor times a small factor: zero remainder unless the product wraps
        if ($urandom_range(0, 7) == 0)
            a = b * (DATA_W'($urandom_range(0, 40)) - DATA_W'(20));
        return {b, a};
    endfunction

    task automatic load_directed();
        logic [DATA_W-1:0] a_list[12];
        logic [DATA_W-1:0] b_list[12];
        a_list = '{INT_MIN, INT_MIN, INT_MAX, INT_MAX, 64'd7, -64'sd7,
                   64'd7, -64'sd7, 64'd0, INT_MIN, 64'd5, INT_MAX};
        b_list = '{MINUS_1, 64'd0, INT_MIN, MINUS_1, 64'd3, 64'd3,
                   -64'sd3, -64'sd3, 64'd9, INT_MAX, INT_MIN, 64'd2};
        foreach (a_list[k]) operand_fifo.push_back({b_list[k], a_list[k]});
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        while (operand_fifo.size() != 0 || remainder_due.size() != 0 || i_s_axis_tvalid)
            @(negedge i_clk);
    endtask

    task automatic write_mode(logic [MODE_W-1:0] m);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= m;
        mode_copy      = m;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        @(negedge i_clk);
    endtask

    assign calm = (in_cnt >= CALM_FROM) && (in_cnt < CALM_TO);

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                in_cnt++;
                remainder_due.push_back(predict_remainder(mode_copy,
                    i_s_axis_tdata[DATA_W-1:0],
                    i_s_axis_tdata[S_TDATA_W-1:DATA_W]));
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (operand_fifo.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= operand_fifo.pop_front();
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off so the pipeline backs up
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && in_cnt >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        t_rem_result w;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (remainder_due.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("ERROR: unexpected transaction rem=%h dz=%b",
                                 o_m_axis_tdata, o_m_axis_tuser);
                end else begin
                    w = remainder_due.pop_front();
                    if (o_m_axis_tdata !== w.rem || o_m_axis_tuser !== w.dz) begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("ERROR: rem exp %h got %h, dz exp %b got %b",
                                     w.rem, o_m_axis_tdata, w.dz, o_m_axis_tuser);
                    end
                end
            end
            i_m_axis_tready <= (hold_left == 0) && (calm || $urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT) begin
            $display("** signed_remainder_three_conventions: FAILED **");
            $finish;
        end
    end

    initial begin
        logic [MODE_W-1:0] modes[10];
        i_rst_n         = 1'b0;
        i_cfg_wr_en     = 1'b0;
        i_cfg_wr_data   = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b0;
        mode_copy       = srem_pkg::MODE_TRUNC;
        in_cnt          = 0;
        err_cnt         = 0;
        hold_left       = 0;
        hold_done       = 1'b0;
        stall_cnt       = 0;
        modes = '{srem_pkg::MODE_TRUNC, srem_pkg::MODE_FLOOR, srem_pkg::MODE_EUCLID, 2'd3,
                  2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                  2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                  2'($urandom_range(0, 3)), 2'($urandom_range(0, 3))};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (modes[p]) begin
            wait_idle();
            write_mode(modes[p]);
            if (p < 4) load_directed();
            repeat (RAND_PER_SET) operand_fifo.push_back(rand_pair());
        end
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (remainder_due.size() != 0) err_cnt++;
        if (err_cnt == 0) begin
            $display("** signed_remainder_three_conventions: PASSED **");
        end else begin
            $display("** signed_remainder_three_conventions: FAILED **");
        end
        $finish;
    end

endmodule
